// File: rtl/pirm_pkg.sv
`timescale 1ns / 1ps

package pirm_pkg;

    // table geometry
    localparam int NUM_IDS = 256;
    localparam int ID_AW   = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

    // field widths
    localparam int ID_W    = 8;
    localparam int LEN_W   = 16;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 8;

    localparam logic [CNT_W-1:0] WINDOW_LIMIT_RESET = 8'd10;

    // upper bound used for the identifier range check
    localparam logic [ID_W:0] ID_LIMIT = (ID_W + 1)'(NUM_IDS);

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        FUNC_MS_TICK   = 2'd0,
        FUNC_PACKET    = 2'd1,
        FUNC_STAT_TICK = 2'd2
    } t_func;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0] rate;
        logic [TIME_W-1:0] interval;
        logic [LEN_W-1:0]  len;
        logic [ID_W-1:0]   id;
    } t_report;

    localparam int REPORT_W = $bits(t_report);

endpackage

// File: rtl/packet_interval_rate_monitor_unit.sv
`timescale 1ns / 1ps

// channel   | dir | signals                         | payload
// ----------+-----+---------------------------------+------------------------------------
// s_axis    | in  | tvalid tready tdata[23:0] tuser | tdata: packet_id, packet_len; tuser: func
// m_axis    | out | tvalid tready tdata[87:0]       | report_id, report_len, interval, rate
// cfg       | in  | i_cfg_valid o_cfg_ready data    | window_limit
//
// millisecond and statistics ticks need no write-back; a packet arrival is a
// read-modify-write of the last-arrival memory (read, then write back)
// the memory read is issued as the arrival is accepted; its data is used in the
// following write-back cycle, during which no item of any kind is accepted
// synchronous active-low reset; per-entry seen bits make the table read as unseen
// input is stalled in the write-back cycle and while a result item is not taken

module packet_interval_rate_monitor_unit
    import pirm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,   // [7:0] packet_id, [23:8] packet_len
    input  logic [1:0]          s_axis_tuser,   // [1:0] func
    // result items
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [REPORT_W-1:0] m_axis_tdata,   // [7:0] id, [23:8] len, [55:24] interval,
                                                // [87:56] rate
    // window limit register
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CNT_W-1:0]    i_cfg_data
);

    // control and stats registers
    logic                    r_busy;
    logic [TIME_W-1:0]       r_ms_clock;
    logic [CNT_W-1:0]        r_window_limit;
    logic [CNT_W-1:0]        r_window_count;
    logic [TIME_W-1:0]       r_byte_accum;
    logic [TIME_W-1:0]       r_window_rate;
    logic                    r_pending;
    t_report                 r_held;
    logic                    r_out_valid;
    t_report                 r_out;

    // arrival held for the write-back cycle
    logic [ID_AW-1:0]        r_idx;
    logic [ID_W-1:0]         r_id;
    logic [LEN_W-1:0]        r_len;
    logic                    r_in_range;
    logic                    r_rd_seen;

    // last-arrival memory and its seen bits
    logic [TIME_W-1:0]       r_last_mem [NUM_IDS];
    logic [TIME_W-1:0]       r_mem_q;
    logic [NUM_IDS-1:0]      r_seen;

    logic                    s_accept;
    t_func                   in_func;
    logic [ID_W-1:0]         in_id;
    logic [LEN_W-1:0]        in_len;
    logic [ID_AW-1:0]        in_idx;
    logic                    in_range;
    logic [TIME_W:0]         n_sum;
    logic                    prev_seen;

    // input unpacking
    assign in_func  = t_func'(s_axis_tuser);
    assign in_id    = s_axis_tdata[ID_W-1:0];
    assign in_len   = s_axis_tdata[ID_W+LEN_W-1:ID_W];
    assign in_idx   = in_id[ID_AW-1:0];
    assign in_range = ({1'b0, in_id} < ID_LIMIT);

    // handshakes
    assign s_axis_tready = !r_busy && !(r_out_valid && !m_axis_tready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // saturating byte sum
    assign n_sum     = {1'b0, r_byte_accum} + (TIME_W + 1)'(in_len);
    // previous arrival counts only if written and nonzero
    assign prev_seen = r_in_range && r_rd_seen && (r_mem_q != '0);

    // memory read port, registered data
    always_ff @(posedge i_clk) begin
        if (s_accept && in_func == FUNC_PACKET) begin
            r_mem_q <= r_last_mem[in_idx];
        end
    end

    // memory write port, in the write-back cycle
    always_ff @(posedge i_clk) begin
        if (r_busy && r_in_range) begin
            r_last_mem[r_idx] <= r_ms_clock;
        end
    end

    // seen bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (r_busy && r_in_range) begin
            r_seen[r_idx] <= 1'b1;
        end
    end

    // arrival payload for the write-back cycle
    always_ff @(posedge i_clk) begin
        if (s_accept && in_func == FUNC_PACKET) begin
            r_idx      <= in_idx;
            r_id       <= in_id;
            r_len      <= in_len;
            r_in_range <= in_range;
            r_rd_seen  <= r_seen[in_idx];
        end
    end

    // held report payload
    always_ff @(posedge i_clk) begin
        if (r_busy && prev_seen && !r_pending) begin
            r_held.id       <= r_id;
            r_held.len      <= r_len;
            r_held.interval <= r_ms_clock - r_mem_q;
            r_held.rate     <= r_window_rate;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s_accept && in_func == FUNC_STAT_TICK && r_pending) begin
            r_out <= r_held;
        end
    end

    // window limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_limit <= WINDOW_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_limit <= i_cfg_data;
        end
    end

    // item processing and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_ms_clock     <= '0;
            r_window_count <= '0;
            r_byte_accum   <= '0;
            r_window_rate  <= '0;
            r_pending      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_busy) begin
                r_busy <= 1'b0;
                if (prev_seen && !r_pending) begin
                    r_pending <= 1'b1;
                end
            end
            if (s_accept) begin
                case (in_func)
                    FUNC_MS_TICK: begin
                        r_ms_clock <= r_ms_clock + 1'b1;
                    end
                    FUNC_PACKET: begin
                        r_busy       <= 1'b1;
                        r_byte_accum <= n_sum[TIME_W] ? '1 : n_sum[TIME_W-1:0];
                    end
                    FUNC_STAT_TICK: begin
                        if (r_window_count >= r_window_limit) begin
                            r_window_count <= '0;
                            r_window_rate  <= r_byte_accum;
                            r_byte_accum   <= '0;
                        end else begin
                            r_window_count <= r_window_count + 1'b1;
                        end
                        if (r_pending) begin
                            r_pending   <= 1'b0;
                            r_out_valid <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    // no item enters during the write-back cycle
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_accept)
        else $error("item accepted during write-back");

    // write-back ends on its own and is never extended
    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("write-back longer than one cycle");

    // a report is held only from an arrival write-back
    a_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pending) |-> $past(r_busy))
        else $error("report held outside an arrival");

    // a new result comes only from a statistics tick with a held report
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s_accept && in_func == FUNC_STAT_TICK && r_pending))
        else $error("result without statistics tick");

    // output is never overwritten while waiting
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s_accept)
        else $error("input accepted while result stalled");
`endif

endmodule

// File: test/tb_packet_interval_rate_monitor_unit.sv
`timescale 1ns / 1ps

module tb_packet_interval_rate_monitor_unit;
    import pirm_pkg::*;

    // tuser code the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int RAND_PHASE_ITEMS = 270;
    localparam int DRAIN_CYCLES     = 12;
    localparam int HOLD_CYCLES      = 400;
    localparam int CYCLE_LIMIT      = 900000;
    localparam int ID_POOL          = 8;

    typedef struct {
        logic [1:0]       func;
        logic [ID_W-1:0]  packet_id;
        logic [LEN_W-1:0] packet_len;
    } t_event;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata = '0;    // [7:0] packet_id, [23:8] packet_len
    logic [1:0]          s_axis_tuser = '0;    // [1:0] func
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [REPORT_W-1:0] m_axis_tdata;         // [7:0] id, [23:8] len, [55:24] interval,
                                               // [87:56] rate
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CNT_W-1:0]    i_cfg_data = '0;

    // predicted block state
    logic [CNT_W-1:0]  win_limit = WINDOW_LIMIT_RESET;
    logic [TIME_W-1:0] ms_now = '0;
    logic [TIME_W-1:0] last_seen [NUM_IDS];
    logic [CNT_W-1:0]  win_ticks = '0;
    logic [TIME_W-1:0] byte_sum = '0;
    logic [TIME_W-1:0] cur_rate = '0;
    logic              slot_full = 1'b0;
    t_report           held;

    t_event  pending_events [$];
    t_report due_reports [$];
    int      events_queued = 0;
    int      events_taken = 0;
    int      mismatches = 0;
    int      cycle_count = 0;

    // sender side
    t_event  tx_event;
    int      tx_wait = 0;
    bit      tx_calm = 1'b0;
    bit      tx_burst = 1'b0;

    // receiver side
    t_report rx_got;
    t_report rx_want;
    int      rx_wait = 0;
    bit      rx_calm = 1'b0;
    logic    rx_hold = 1'b0;
    int      hold_left = 0;
    int      hold_requests = 0;
    int      holds_served = 0;

    packet_interval_rate_monitor_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        foreach (last_seen[k]) last_seen[k] = '0;
    end

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // arrival bookkeeping, rate window and report slot for one accepted item
    task automatic apply_event(input t_event ev);
        logic [TIME_W:0] sum;
        case (ev.func)
            FUNC_MS_TICK: begin
                ms_now = ms_now + 1'b1;
            end
            FUNC_PACKET: begin
                if (ev.packet_id < NUM_IDS) begin
                    if (last_seen[ev.packet_id] != '0 && !slot_full) begin
                        held.id       = ev.packet_id;
                        held.len      = ev.packet_len;
                        held.interval = ms_now - last_seen[ev.packet_id];
                        held.rate     = cur_rate;
                        slot_full     = 1'b1;
                    end
                    last_seen[ev.packet_id] = ms_now;
                end
                sum = {1'b0, byte_sum} + (TIME_W + 1)'(ev.packet_len);
                byte_sum = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            end
            FUNC_STAT_TICK: begin
                if (win_ticks >= win_limit) begin
                    win_ticks = '0;
                    cur_rate  = byte_sum;
                    byte_sum  = '0;
                end else begin
                    win_ticks = win_ticks + 1'b1;
                end
                if (slot_full) begin
                    slot_full = 1'b0;
                    due_reports.push_back(held);
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_event make_event(input logic [1:0] func, input logic [ID_W-1:0] id,
                                          input logic [LEN_W-1:0] len);
        t_event ev;
        ev.func       = func;
        ev.packet_id  = id;
        ev.packet_len = len;
        return ev;
    endfunction

    task automatic offer(input t_event ev);
        pending_events.push_back(ev);
        events_queued++;
    endtask

    // mostly ticks and arrivals on a small id pool so intervals get reported
    task automatic queue_random(input int count);
        t_event ev;
        int     pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 34)
                ev.func = FUNC_MS_TICK;
            else if (pick < 70)
                ev.func = FUNC_PACKET;
            else if (pick < 93)
                ev.func = FUNC_STAT_TICK;
            else
                ev.func = FUNC_UNUSED;
            if ($urandom_range(0, 9) < 7)
                ev.packet_id = ID_W'($urandom_range(0, ID_POOL - 1));
            else
                ev.packet_id = ID_W'($urandom);
            case ($urandom_range(0, 7))
                0:       ev.packet_len = '0;
                1:       ev.packet_len = '1;
                default: ev.packet_len = LEN_W'($urandom);
            endcase
            offer(ev);
        end
    endtask

    // wait until every item is taken and every report is back, then let the block go quiet
    task automatic settle();
        do @(posedge i_clk);
        while (events_taken != events_queued || due_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_limit(input logic [CNT_W-1:0] value);
        settle();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        win_limit = value;
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_event(tx_event);
                events_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    tx_event = pending_events.pop_front();
                    s_axis_tdata  <= {tx_event.packet_len, tx_event.packet_id};
                    s_axis_tuser  <= tx_event.func;
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        tx_calm = !tx_calm;
                    tx_wait = (tx_calm || tx_burst) ? 0 : $urandom_range(0, 14);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, one per request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0)
                rx_hold <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            rx_hold <= 1'b1;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_got = m_axis_tdata;
                if (due_reports.size() == 0) begin
                    $error("unexpected report item: id %0d len %0d interval %0d rate %0d",
                           rx_got.id, rx_got.len, rx_got.interval, rx_got.rate);
                    mismatches++;
                end else begin
                    rx_want = due_reports.pop_front();
                    if (rx_got.id !== rx_want.id) begin
                        $error("report_id: expected %0d, got %0d", rx_want.id, rx_got.id);
                        mismatches++;
                    end
                    if (rx_got.len !== rx_want.len) begin
                        $error("report_len: expected %0d, got %0d", rx_want.len, rx_got.len);
                        mismatches++;
                    end
                    if (rx_got.interval !== rx_want.interval) begin
                        $error("report_interval: expected %0d, got %0d",
                               rx_want.interval, rx_got.interval);
                        mismatches++;
                    end
                    if (rx_got.rate !== rx_want.rate) begin
                        $error("report_rate: expected %0d, got %0d", rx_want.rate, rx_got.rate);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
            end
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // arrival at clock zero stays unseen, unused kind, slot occupied, window close
        offer(make_event(FUNC_PACKET, 8'd5, 16'd100));
        offer(make_event(FUNC_UNUSED, 8'hFF, 16'hFFFF));
        offer(make_event(FUNC_MS_TICK, 8'd0, 16'd0));
        offer(make_event(FUNC_PACKET, 8'd5, 16'hFFFF));
        offer(make_event(FUNC_MS_TICK, 8'd0, 16'd0));
        offer(make_event(FUNC_MS_TICK, 8'd0, 16'd0));
        offer(make_event(FUNC_PACKET, 8'd5, 16'd0));
        offer(make_event(FUNC_PACKET, 8'hFF, 16'd7));
        offer(make_event(FUNC_MS_TICK, 8'd0, 16'd0));
        offer(make_event(FUNC_PACKET, 8'd5, 16'd1));
        offer(make_event(FUNC_STAT_TICK, 8'd0, 16'd0));
        offer(make_event(FUNC_STAT_TICK, 8'd0, 16'd0));
        offer(make_event(FUNC_PACKET, 8'hFF, 16'hFFFF));
        offer(make_event(FUNC_PACKET, 8'd0, 16'd0));
        offer(make_event(FUNC_STAT_TICK, 8'd0, 16'd0));
        offer(make_event(FUNC_UNUSED, 8'd0, 16'd0));
        for (int n = 0; n < 8; n++)
            offer(make_event(FUNC_STAT_TICK, 8'd0, 16'd0));
        offer(make_event(FUNC_MS_TICK, 8'd0, 16'd0));
        offer(make_event(FUNC_PACKET, 8'd0, 16'd3));
        offer(make_event(FUNC_STAT_TICK, 8'd0, 16'd0));

        // every tick closes a window
        write_window_limit(8'd0);
        queue_random(RAND_PHASE_ITEMS);

        // widest window, lets the tick count grow
        write_window_limit(8'd255);
        queue_random(RAND_PHASE_ITEMS);

        // lowered limit with the count above it, output held off while input keeps coming
        write_window_limit(8'd3);
        hold_requests <= hold_requests + 1;
        tx_burst = 1'b1;
        queue_random(RAND_PHASE_ITEMS);
        settle();
        tx_burst = 1'b0;

        write_window_limit(CNT_W'($urandom_range(1, 254)));
        queue_random(RAND_PHASE_ITEMS);

        write_window_limit(CNT_W'($urandom));
        queue_random(RAND_PHASE_ITEMS);

        settle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: packet_interval_rate_monitor_unit.f
rtl/pirm_pkg.sv
rtl/packet_interval_rate_monitor_unit.sv
test/tb_packet_interval_rate_monitor_unit.sv
